@@ design/qmn_pkg.sv @@
package qmn_pkg;

  localparam int unsigned CompW    = 32;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned SumW     = 66;
  localparam int unsigned MagW     = 65;
  localparam int unsigned LenW     = 7;
  localparam int unsigned AlW      = 31;
  localparam int unsigned SqW      = 62;
  localparam int unsigned SsW      = 64;
  localparam int unsigned RootW    = 32;
  localparam int unsigned RemW     = 34;
  localparam int unsigned SqSteps  = 32;
  localparam int unsigned QuoW     = 31;
  localparam int unsigned DivSteps = 31;
  localparam int unsigned FracBits = 30;

  localparam logic [QuoW-1:0] OneQ30 = QuoW'(1) << FracBits;

  typedef struct packed {
    logic [3:0][AlW-1:0] mag;
    logic [3:0]          neg;
    logic                zero;
  } side_t;

  typedef struct packed {
    logic [3:0] neg;
    logic       zero;
  } sign_t;

endpackage

@@ design/qmn_div_lane.sv @@
module qmn_div_lane
  import qmn_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [AlW-1:0]   mag_i,
  input  logic [RootW-1:0] root_i,
  output logic [QuoW-1:0]  quo_o
);

  logic [RootW-1:0] rem_q  [DivSteps];
  logic [QuoW-1:0]  low_q  [DivSteps];
  logic [QuoW-1:0]  quo_q  [DivSteps];
  logic [RootW-1:0] root_q [DivSteps];

  logic [61:0] num;
  assign num = {mag_i, {FracBits{1'b0}}} + 62'(root_i >> 1);

  for (genvar j = 0; j < DivSteps; j++) begin : g_step
    logic [RootW-1:0] rem_in;
    logic [QuoW-1:0]  low_in;
    logic [QuoW-1:0]  quo_in;
    logic [RootW-1:0] root_in;
    logic [RootW:0]   trial;
    logic [RootW+1:0] diff;

    if (j == 0) begin : g_first
      assign rem_in  = {1'b0, num[61:31]};
      assign low_in  = num[30:0];
      assign quo_in  = '0;
      assign root_in = root_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign low_in  = low_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign root_in = root_q[j-1];
    end

    assign trial = {rem_in, low_in[QuoW-1]};
    assign diff  = {1'b0, trial} - {2'b00, root_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= diff[RootW+1] ? trial[RootW-1:0] : diff[RootW-1:0];
        low_q[j]  <= {low_in[QuoW-2:0], 1'b0};
        quo_q[j]  <= {quo_in[QuoW-2:0], ~diff[RootW+1]};
        root_q[j] <= root_in;
      end
    end
  end

  assign quo_o = quo_q[DivSteps-1];

endmodule

@@ design/quaternion_multiply_normalize_unit.sv @@
// Takes one beat holding two Q2.30 quaternions every cycle and returns their Hamilton
// product scaled to unit length as Q2.30 components, with tuser set when the product is
// exactly zero. The pipeline is seven stages of products, sums, alignment and squares, a
// 32-stage square root that settles one root bit per stage, 31 stages of dividers that
// settle one quotient bit per stage, and the output register. Throughput is one beat per
// cycle; the whole pipeline holds while the output beat is not taken.
module quaternion_multiply_normalize_unit
  import qmn_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, 32 bits each from the lowest bit up.
  input  logic [255:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // r_w, r_x, r_y, r_z, 32 bits each from the lowest bit up.
  output logic [127:0] m_axis_tdata_o,
  // zero_norm.
  output logic [0:0]   m_axis_tuser_o
);

  logic en;
  logic out_valid_q;
  assign en              = ~out_valid_q | m_axis_tready_i;
  assign s_axis_tready_o = en;

  logic signed [CompW-1:0] aw, ax, ay, az, bw, bx, by, bz;
  assign aw = s_axis_tdata_i[31:0];
  assign ax = s_axis_tdata_i[63:32];
  assign ay = s_axis_tdata_i[95:64];
  assign az = s_axis_tdata_i[127:96];
  assign bw = s_axis_tdata_i[159:128];
  assign bx = s_axis_tdata_i[191:160];
  assign by = s_axis_tdata_i[223:192];
  assign bz = s_axis_tdata_i[255:224];

  logic [6:0] vld_q;

  logic signed [ProdW-1:0] prod_q [16];
  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q[0]  <= aw * bw;
      prod_q[1]  <= ax * bx;
      prod_q[2]  <= ay * by;
      prod_q[3]  <= az * bz;
      prod_q[4]  <= aw * bx;
      prod_q[5]  <= ax * bw;
      prod_q[6]  <= ay * bz;
      prod_q[7]  <= az * by;
      prod_q[8]  <= aw * by;
      prod_q[9]  <= ax * bz;
      prod_q[10] <= ay * bw;
      prod_q[11] <= az * bx;
      prod_q[12] <= aw * bz;
      prod_q[13] <= ax * by;
      prod_q[14] <= ay * bx;
      prod_q[15] <= az * bw;
    end
  end

  logic signed [SumW-1:0] ext [16];
  for (genvar i = 0; i < 16; i++) begin : g_ext
    assign ext[i] = {{(SumW-ProdW){prod_q[i][ProdW-1]}}, prod_q[i]};
  end

  logic signed [SumW-1:0] comp_q [4];
  always_ff @(posedge clk_i) begin
    if (en) begin
      comp_q[0] <= ext[0] - ext[1] - ext[2] - ext[3];
      comp_q[1] <= ext[4] + ext[5] + ext[6] - ext[7];
      comp_q[2] <= ext[8] - ext[9] + ext[10] + ext[11];
      comp_q[3] <= ext[12] + ext[13] - ext[14] + ext[15];
    end
  end

  logic [MagW-1:0] mag_q [4];
  logic [3:0]      neg3_q;
  logic [MagW-1:0] orv_q;
  logic [MagW-1:0] mag_d [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_d[i] = comp_q[i][SumW-1] ? MagW'(-comp_q[i]) : MagW'(comp_q[i]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        mag_q[i]  <= mag_d[i];
        neg3_q[i] <= comp_q[i][SumW-1];
      end
      orv_q <= mag_d[0] | mag_d[1] | mag_d[2] | mag_d[3];
    end
  end

  logic [LenW-1:0] len_d;
  always_comb begin
    len_d = '0;
    for (int i = 0; i < MagW; i++) begin
      if (orv_q[i]) begin
        len_d = LenW'(i + 1);
      end
    end
  end

  logic [MagW-1:0] mag4_q [4];
  logic [3:0]      neg4_q;
  logic [LenW-1:0] len_q;
  logic            zero4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      mag4_q  <= mag_q;
      neg4_q  <= neg3_q;
      len_q   <= len_d;
      zero4_q <= (orv_q == '0);
    end
  end

  side_t side5_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        side5_q.mag[i] <= AlW'({mag4_q[i], {AlW{1'b0}}} >> len_q);
      end
      side5_q.neg  <= neg4_q;
      side5_q.zero <= zero4_q;
    end
  end

  logic [SqW-1:0] sq_q [4];
  side_t          side6_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq_q[i] <= SqW'(side5_q.mag[i]) * SqW'(side5_q.mag[i]);
      end
      side6_q <= side5_q;
    end
  end

  logic [SsW-1:0] ss_q;
  side_t          side7_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ss_q    <= SsW'(sq_q[0]) + SsW'(sq_q[1]) + SsW'(sq_q[2]) + SsW'(sq_q[3]);
      side7_q <= side6_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[5:0], s_axis_tvalid_i};
    end
  end

  logic [RemW-1:0]  sq_rem_q  [SqSteps];
  logic [RootW-1:0] sq_root_q [SqSteps];
  logic [SsW-1:0]   sq_src_q  [SqSteps];
  side_t            sq_side_q [SqSteps];
  logic [SqSteps-1:0] sq_vld_q;

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [SsW-1:0]   src_in;
    side_t            side_in;
    logic             vld_in;
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign src_in  = ss_q;
      assign side_in = side7_q;
      assign vld_in  = vld_q[6];
    end else begin : g_next
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign src_in  = sq_src_q[k-1];
      assign side_in = sq_side_q[k-1];
      assign vld_in  = sq_vld_q[k-1];
    end

    assign rem_sh = {rem_in[RemW-3:0], src_in[SsW-1:SsW-2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
        sq_root_q[k] <= {root_in[RootW-2:0], ge};
        sq_src_q[k]  <= {src_in[SsW-3:0], 2'b00};
        sq_side_q[k] <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k] <= 1'b0;
      end else if (en) begin
        sq_vld_q[k] <= vld_in;
      end
    end
  end

  side_t            root_side;
  logic [RootW-1:0] root;
  assign root_side = sq_side_q[SqSteps-1];
  assign root      = sq_root_q[SqSteps-1];

  logic [QuoW-1:0] quo [4];
  for (genvar i = 0; i < 4; i++) begin : g_lane
    qmn_div_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .mag_i  (root_side.mag[i]),
      .root_i (root),
      .quo_o  (quo[i])
    );
  end

  sign_t dv_sign_q [DivSteps];
  logic [DivSteps-1:0] dv_vld_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_sign_q[0] <= '{neg: root_side.neg, zero: root_side.zero};
      for (int j = 1; j < DivSteps; j++) begin
        dv_sign_q[j] <= dv_sign_q[j-1];
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q <= '0;
    end else if (en) begin
      dv_vld_q <= {dv_vld_q[DivSteps-2:0], sq_vld_q[SqSteps-1]};
    end
  end

  sign_t            fin;
  logic [127:0]     out_data_d;
  logic [127:0]     out_data_q;
  logic             out_zero_q;
  assign fin = dv_sign_q[DivSteps-1];
  always_comb begin
    logic [QuoW-1:0]  sat;
    logic [CompW-1:0] mag;
    for (int i = 0; i < 4; i++) begin
      sat = (quo[i] > OneQ30) ? OneQ30 : quo[i];
      mag = CompW'(sat);
      if (fin.zero) begin
        out_data_d[i*CompW +: CompW] = '0;
      end else if (fin.neg[i]) begin
        out_data_d[i*CompW +: CompW] = -mag;
      end else begin
        out_data_d[i*CompW +: CompW] = mag;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_zero_q <= fin.zero;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_vld_q[DivSteps-1];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_zero_q;

endmodule

@@ design/qmn_checker.sv @@
module qmn_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic [255:0] s_axis_tdata_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [127:0] m_axis_tdata_o,
  input logic [0:0]   m_axis_tuser_o
);

  function automatic logic in_range(input logic [31:0] v);
    return ($signed(v) <= 32'sd1073741824) && ($signed(v) >= -32'sd1073741824);
  endfunction

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("Output beat changed while stalled.");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("Zero-norm beat carries non-zero components.");

  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o != '0)
    else $error("Unit quaternion output is all zero.");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> in_range(m_axis_tdata_o[31:0]) && in_range(m_axis_tdata_o[63:32])
      && in_range(m_axis_tdata_o[95:64]) && in_range(m_axis_tdata_o[127:96]))
    else $error("Output component exceeds unit magnitude.");

endmodule

bind quaternion_multiply_normalize_unit qmn_checker u_qmn_checker (.*);

@@ test/tb_quaternion_multiply_normalize_unit.sv @@
`timescale 1ns / 100ps

module tb_quaternion_multiply_normalize_unit;
  import qmn_pkg::*;

  typedef struct {
    logic signed [31:0] w, x, y, z;
    logic               zero_norm;
  } unit_quat_t;

  class unit_quat_scoreboard;
    unit_quat_t pending[$];
    int unsigned errors;
    int unsigned beats_out;
    int unsigned zero_seen;

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function automatic unit_quat_t normalised_product(logic [255:0] d);
      logic signed [67:0] a[4];
      logic signed [67:0] b[4];
      logic signed [67:0] c[4];
      logic [67:0] mag_full[4];
      logic [63:0] mag[4];
      logic [63:0] sumsq;
      logic [63:0] root;
      logic [127:0] quo;
      logic [31:0] res[4];
      int lmax;
      unit_quat_t r;
      for (int i = 0; i < 4; i++) begin
        a[i] = 68'(signed'(d[32*i +: 32]));
        b[i] = 68'(signed'(d[128 + 32*i +: 32]));
      end
      c[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
      c[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
      c[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
      c[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
      lmax = 0;
      for (int i = 0; i < 4; i++) begin
        mag_full[i] = c[i] < 0 ? 68'(-c[i]) : 68'(c[i]);
        for (int k = 0; k < 68; k++) if (mag_full[i][k] && k + 1 > lmax) lmax = k + 1;
      end
      if (lmax == 0) begin
        r.w = 0; r.x = 0; r.y = 0; r.z = 0; r.zero_norm = 1'b1;
        return r;
      end
      sumsq = 0;
      for (int i = 0; i < 4; i++) begin
        if (lmax <= 31) mag[i] = 64'(mag_full[i] << (31 - lmax));
        else mag[i] = 64'(mag_full[i] >> (lmax - 31));
        sumsq = sumsq + mag[i] * mag[i];
      end
      root = int_sqrt(sumsq);
      for (int i = 0; i < 4; i++) begin
        quo = ((128'(mag[i]) << 30) + 128'(root >> 1)) / 128'(root);
        if (quo > 128'(OneQ30)) quo = 128'(OneQ30);
        res[i] = c[i] < 0 ? 32'(-quo) : 32'(quo);
      end
      r.w = res[0]; r.x = res[1]; r.y = res[2]; r.z = res[3]; r.zero_norm = 1'b0;
      return r;
    endfunction

    function void note_input(logic [255:0] d);
      pending.push_back(normalised_product(d));
    endfunction

    function void check_result(logic [127:0] d, logic zn);
      unit_quat_t e;
      beats_out++;
      if (pending.size() == 0) begin
        $error("Result beat arrived with nothing expected.");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (zn) zero_seen++;
      if (d[31:0] !== e.w) begin $error("r_w exp %0d got %0d", e.w, $signed(d[31:0])); errors++; end
      if (d[63:32] !== e.x) begin $error("r_x exp %0d got %0d", e.x, $signed(d[63:32])); errors++; end
      if (d[95:64] !== e.y) begin $error("r_y exp %0d got %0d", e.y, $signed(d[95:64])); errors++; end
      if (d[127:96] !== e.z) begin $error("r_z exp %0d got %0d", e.z, $signed(d[127:96])); errors++; end
      if (zn !== e.zero_norm) begin
        $error("zero_norm exp %0b got %0b", e.zero_norm, zn); errors++;
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [255:0] s_axis_tdata_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [127:0] m_axis_tdata_o;
  logic [0:0]   m_axis_tuser_o;

  unit_quat_scoreboard quat_board;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned beats_in;

  quaternion_multiply_normalize_unit DUT (.*);

  always begin
    clk_i = 1'b0; #10;
    clk_i = 1'b1; #10;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        quat_board.note_input(s_axis_tdata_i);
        beats_in++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) quat_board.check_result(m_axis_tdata_o, m_axis_tuser_o[0]);
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  function automatic logic [31:0] random_component();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(signed'($urandom_range(8)) - 4);
      3: return 32'h4000_0000;
      4: return 32'hc000_0000;
      5: return 32'(signed'($urandom_range(2000)) - 1000);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_pair(logic [255:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= d;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic send_random(int n);
    logic [255:0] d;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 8; k++) d[32*k +: 32] = random_component();
      if ($urandom_range(19) == 0) d[127:0] = '0;
      else if ($urandom_range(19) == 0) d[255:128] = '0;
      send_pair(d);
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (quat_board.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    #100_000_000;
    $display("** quaternion_multiply_normalize_unit: FAILED **");
    $finish;
  end

  initial begin
    logic [255:0] d;
    quat_board = new();
    beats_in = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pair('0);
    send_pair({128'd0, {4{32'h4000_0000}}});
    send_pair({{4{32'h8000_0000}}, {4{32'h8000_0000}}});
    send_pair({{4{32'h7fff_ffff}}, {4{32'h7fff_ffff}}});
    send_pair({{4{32'h8000_0000}}, {4{32'h7fff_ffff}}});
    send_pair({{4{32'hffff_ffff}}, {4{32'hffff_ffff}}});
    send_pair({96'd0, 32'h4000_0000, 96'd0, 32'h4000_0000});
    send_pair({32'd1, 96'd0, 96'd0, 32'd1});
    send_pair({128'd0, 32'd0, 32'd0, 32'hffff_ffff, 32'd0});
    send_pair({32'h0000_0003, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_fffd,
               32'h1234_5678, 32'hedcb_a988, 32'd0, 32'h4000_0000});
    for (int i = 0; i < 4; i++) begin
      d = '0;
      d[32*i +: 32] = 32'hc000_0000;
      d[128 + 32*((i + 1) % 4) +: 32] = 32'h4000_0000;
      send_pair(d);
    end
    drain();

    send_idle_pct = 32;
    recv_idle_pct = 69;
    send_random(400);
    drain();
    send_idle_pct = 69;
    recv_idle_pct = 32;
    send_random(400);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(400);

    drain();
    repeat (100) @(posedge clk_i);
    $display("Sent %0d quaternion pairs and checked %0d normalised products, %0d of them zero.",
             beats_in, quat_board.beats_out, quat_board.zero_seen);
    if (quat_board.errors == 0 && quat_board.pending.size() == 0) begin
      $display("** quaternion_multiply_normalize_unit: PASSED **");
    end else begin
      $display("** quaternion_multiply_normalize_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/qmn_pkg.sv
design/qmn_div_lane.sv
design/quaternion_multiply_normalize_unit.sv
design/qmn_checker.sv
test/tb_quaternion_multiply_normalize_unit.sv
